// ----- hdl/htc_pkg.sv -----
// ============================================================================
// htc_pkg
// shared types, constants and codes of the histogram tail compressor
// ============================================================================
package htc_pkg;

    // defaults of the top level parameters
    localparam int MAX_BINS_DEF   = 64;
    localparam int VALUE_BITS_DEF = 16;

    // fixed field widths
    localparam int FIELD_W  = 16;
    localparam int IDX_W    = 6;
    localparam int MERGED_W = 22;

    // depth of the queue between front and back
    localparam int QUEUE_DEPTH = 2;

    // configuration register map
    localparam int CFG_IDX_W = 2;
    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;
    localparam t_cfg_idx REG_TAIL_BOUND = 2'd0;
    localparam t_cfg_idx REG_MIN_SAMPLE = 2'd1;

    localparam logic [FIELD_W-1:0] TAIL_BOUND_RST = 16'd328;
    localparam logic [FIELD_W-1:0] MIN_SAMPLE_RST = 16'd0;

    typedef logic [IDX_W-1:0] t_idx;

    typedef enum logic [2:0] {
        ST_OK     = 3'd0,
        ST_ZERO   = 3'd1,
        ST_SINGLE = 3'd2,
        ST_SMALL  = 3'd3,
        ST_IMPL   = 3'd4
    } t_status;

    // input word
    typedef struct packed {
        logic [FIELD_W-1:0] bin_value;
        logic [FIELD_W-1:0] sample_size;
        logic               last_bin;
    } t_in_word;

    // result word
    typedef struct packed {
        t_idx                bin_index;
        logic [MERGED_W-1:0] merged_value;
        t_idx                left_cut;
        t_idx                right_cut;
        t_idx                peak_index;
        t_status             status;
        logic                last_result;
    } t_out_word;

    // classified word, front to back
    typedef struct packed {
        logic [FIELD_W-1:0] bin_value;
        t_idx               bin_idx;
        logic               keep;
        logic               last_bin;
        logic [FIELD_W-1:0] sample_size;
    } t_cls_word;

    // back end sequencer
    typedef enum logic [5:0] {
        S_LOAD  = 6'b000001,
        S_LSCAN = 6'b000010,
        S_RSCAN = 6'b000100,
        S_PEAK  = 6'b001000,
        S_EMIT  = 6'b010000,
        S_STAT  = 6'b100000
    } t_back_state;

endpackage

// ----- hdl/histogram_tail_compressor.sv -----
// ============================================================================
// histogram_tail_compressor
// loads a histogram bin by bin, trims both tails against a bound, folds the
// tail mass into the edge bins and emits the kept bins with the peak index
// ============================================================================
//
//  channel  | ports                                    | direction | flow
//  ---------+------------------------------------------+-----------+--------------
//  in       | i_in_valid, o_in_stall, i_in             | in        | valid / stall
//  out      | o_out_valid, i_out_stall, o_out          | out       | valid / stall
//  cfg      | i_cfg_valid, o_cfg_ready, i_cfg_index,   | in        | valid / ready
//           | i_cfg_data                               |           |
//
//  bins enter at one word per cycle, unless stalled, into a two-word queue; the
//    back end takes them into its bin store at one per cycle while loading
//  after the last bin the back end runs a left scan, a right scan, peak search
//    and emission, or stops at a single status result; all of it goes
//    through the single read port of the bin store: every bin is loaded once,
//    the tails are read once by the scans and the kept range twice
//  input stalls once the queue fills while the back end works on a histogram
//  result stalls hold the emission walk; the output register frees the back
//  synchronous active-low reset; the bin store is not cleared
//
module histogram_tail_compressor #(
    parameter int MAX_BINS   = htc_pkg::MAX_BINS_DEF,
    parameter int VALUE_BITS = htc_pkg::VALUE_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,

    // bin words
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  htc_pkg::t_in_word             i_in,

    // result words
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output htc_pkg::t_out_word            o_out,

    // configuration writes
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  htc_pkg::t_cfg_idx             i_cfg_index,
    input  logic [htc_pkg::FIELD_W-1:0]   i_cfg_data
);

    // configuration registers
    logic [htc_pkg::FIELD_W-1:0] r_tail_bound;
    logic [htc_pkg::FIELD_W-1:0] r_min_sample;

    // front to queue
    logic               s_push;
    htc_pkg::t_cls_word s_push_word;
    logic               s_full;

    // queue to back
    logic               s_pop;
    htc_pkg::t_cls_word s_pop_word;
    logic               s_empty;

    // writes are always taken; the user must write only while the block is idle, it does not enforce this
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tail_bound <= htc_pkg::TAIL_BOUND_RST;
            r_min_sample <= htc_pkg::MIN_SAMPLE_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                htc_pkg::REG_TAIL_BOUND: r_tail_bound <= i_cfg_data;
                htc_pkg::REG_MIN_SAMPLE: r_min_sample <= i_cfg_data;
                default: begin
                    // unmapped index, write dropped
                end
            endcase
        end
    end

    // front: takes words, masks values, tags bin slots, saturates the count
    htc_front #(
        .MAX_BINS   (MAX_BINS),
        .VALUE_BITS (VALUE_BITS)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in       (i_in),
        .o_push     (s_push),
        .o_word     (s_push_word),
        .i_full     (s_full)
    );

    // decoupling queue
    htc_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (s_push),
        .i_data  (s_push_word),
        .o_full  (s_full),
        .i_pop   (s_pop),
        .o_data  (s_pop_word),
        .o_empty (s_empty)
    );

    // back: bin store, scans, peak search, emission and output register
    htc_back #(
        .MAX_BINS   (MAX_BINS),
        .VALUE_BITS (VALUE_BITS)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_word       (s_pop_word),
        .i_empty      (s_empty),
        .o_pop        (s_pop),
        .i_tail_bound (r_tail_bound),
        .i_min_sample (r_min_sample),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_out        (o_out)
    );

endmodule

// ----- hdl/htc_front.sv -----
// ============================================================================
// htc_front
// accepts input words, masks the value and tags each with its bin slot
// ============================================================================
module htc_front #(
    parameter int MAX_BINS   = htc_pkg::MAX_BINS_DEF,
    parameter int VALUE_BITS = htc_pkg::VALUE_BITS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  htc_pkg::t_in_word   i_in,
    output logic                o_push,
    output htc_pkg::t_cls_word  o_word,
    input  logic                i_full
);

    localparam int CW = $clog2(MAX_BINS + 1);
    localparam int IW = $clog2(MAX_BINS);
    localparam int SB = (VALUE_BITS < htc_pkg::FIELD_W) ? VALUE_BITS : htc_pkg::FIELD_W;
    localparam logic [htc_pkg::FIELD_W-1:0] VMASK =
        {htc_pkg::FIELD_W{1'b1}} >> (htc_pkg::FIELD_W - SB);

    logic [CW-1:0] r_count;
    logic [CW-1:0] n_count;
    logic          s_keep;

    assign s_keep     = r_count < CW'(MAX_BINS);
    assign o_in_stall = i_full;
    assign o_push     = i_in_valid && !i_full;

    always_comb begin
        o_word.bin_value   = i_in.bin_value & VMASK;
        o_word.bin_idx     = htc_pkg::t_idx'(r_count[IW-1:0]);
        o_word.keep        = s_keep;
        o_word.last_bin    = i_in.last_bin;
        o_word.sample_size = i_in.sample_size;
    end

    // count saturates at the bin limit, cleared by the last bin
    always_comb begin
        n_count = r_count;
        if (o_push) begin
            if (i_in.last_bin) begin
                n_count = '0;
            end else if (s_keep) begin
                n_count = r_count + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

endmodule

// ----- hdl/htc_fifo.sv -----
// ============================================================================
// htc_fifo
// short queue of classified words between front and back
// ============================================================================
module htc_fifo (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  htc_pkg::t_cls_word  i_data,
    output logic                o_full,
    input  logic                i_pop,
    output htc_pkg::t_cls_word  o_data,
    output logic                o_empty
);

    localparam int DEPTH = htc_pkg::QUEUE_DEPTH;
    localparam int PW    = $clog2(DEPTH);
    localparam int CNTW  = $clog2(DEPTH + 1);

    htc_pkg::t_cls_word r_mem [DEPTH];
    logic [PW-1:0]      r_wr_ptr;
    logic [PW-1:0]      r_rd_ptr;
    logic [CNTW-1:0]    r_count;
    logic [PW-1:0]      n_wr_ptr;
    logic [PW-1:0]      n_rd_ptr;
    logic [CNTW-1:0]    n_count;

    assign o_full  = r_count == CNTW'(DEPTH);
    assign o_empty = r_count == '0;
    assign o_data  = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == PW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == PW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        case ({i_push, i_pop})
            2'b10:   n_count = r_count + 1'b1;
            2'b01:   n_count = r_count - 1'b1;
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

endmodule

// ----- hdl/htc_back.sv -----
// ============================================================================
// htc_back
// bin store, tail scans, peak search and result emission
// ============================================================================
module htc_back #(
    parameter int MAX_BINS   = htc_pkg::MAX_BINS_DEF,
    parameter int VALUE_BITS = htc_pkg::VALUE_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  htc_pkg::t_cls_word            i_word,
    input  logic                          i_empty,
    output logic                          o_pop,
    input  logic [htc_pkg::FIELD_W-1:0]   i_tail_bound,
    input  logic [htc_pkg::FIELD_W-1:0]   i_min_sample,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output htc_pkg::t_out_word            o_out
);

    localparam int IW = $clog2(MAX_BINS);
    localparam int SB = (VALUE_BITS < htc_pkg::FIELD_W) ? VALUE_BITS : htc_pkg::FIELD_W;
    localparam int FW = htc_pkg::FIELD_W;

    htc_pkg::t_back_state r_state, n_state;

    logic [SB-1:0]      r_mem [MAX_BINS];
    logic [SB-1:0]      r_rd_data;
    logic [IW-1:0]      r_rd_idx;
    logic               r_rd_valid, n_rd_valid;

    logic [IW-1:0]      r_addr, n_addr;
    logic               r_more, n_more;
    logic [FW-1:0]      r_sum, n_sum;
    logic [FW-1:0]      r_lsum, n_lsum;
    logic [FW-1:0]      r_rsum, n_rsum;
    logic [IW-1:0]      r_i, n_i;
    logic [IW-1:0]      r_j, n_j;
    logic [IW-1:0]      r_last_idx, n_last_idx;
    logic [FW-1:0]      r_ss, n_ss;
    logic [SB-1:0]      r_best, n_best;
    logic [IW-1:0]      r_peak, n_peak;
    htc_pkg::t_out_word r_stat_word, n_stat_word;
    logic               r_out_valid, n_out_valid;
    htc_pkg::t_out_word r_out, n_out;

    logic [FW:0]        s_sum;
    logic               s_hit;
    logic               s_small;
    logic               s_can_load;
    logic               s_out_load;
    logic               s_fin;
    logic               s_issue;
    logic               s_consume;
    logic [IW-1:0]      s_stop;
    logic [FW-1:0]      s_fold;
    logic [FW:0]        s_merged;
    htc_pkg::t_out_word s_emit_word;
    htc_pkg::t_out_word s_impl_word;

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    assign s_sum      = {1'b0, r_sum} + (FW+1)'(r_rd_data);
    assign s_hit      = s_sum > {1'b0, i_tail_bound};
    assign s_small    = (i_min_sample != '0) && (r_ss < i_min_sample);
    assign s_can_load = !r_out_valid || !i_out_stall;
    assign s_stop     = (r_state == htc_pkg::S_LSCAN) ? r_last_idx : r_j;

    // edge bins carry the folded tails, cuts differ whenever this is used
    assign s_fold   = (r_rd_idx == r_i) ? r_lsum :
                      (r_rd_idx == r_j) ? r_rsum : '0;
    assign s_merged = {1'b0, s_fold} + (FW+1)'(r_rd_data);

    always_comb begin
        s_emit_word.bin_index    = htc_pkg::t_idx'(r_rd_idx);
        s_emit_word.merged_value = htc_pkg::MERGED_W'(s_merged);
        s_emit_word.left_cut     = htc_pkg::t_idx'(r_i);
        s_emit_word.right_cut    = htc_pkg::t_idx'(r_j);
        s_emit_word.peak_index   = htc_pkg::t_idx'(r_peak);
        s_emit_word.status       = htc_pkg::ST_OK;
        s_emit_word.last_result  = r_rd_idx == r_j;

        s_impl_word              = '0;
        s_impl_word.status       = htc_pkg::ST_IMPL;
        s_impl_word.last_result  = 1'b1;
    end

    always_comb begin
        n_state     = r_state;
        n_addr      = r_addr;
        n_more      = r_more;
        n_sum       = r_sum;
        n_lsum      = r_lsum;
        n_rsum      = r_rsum;
        n_i         = r_i;
        n_j         = r_j;
        n_last_idx  = r_last_idx;
        n_ss        = r_ss;
        n_best      = r_best;
        n_peak      = r_peak;
        n_stat_word = r_stat_word;
        n_out_valid = s_can_load ? 1'b0 : r_out_valid;
        n_out       = r_out;
        o_pop       = 1'b0;
        s_fin       = 1'b0;
        s_issue     = 1'b0;
        s_consume   = 1'b1;
        s_out_load  = 1'b0;

        case (r_state)
            htc_pkg::S_LOAD: begin
                o_pop = !i_empty;
                if (!i_empty && i_word.last_bin) begin
                    n_ss       = i_word.sample_size;
                    n_last_idx = i_word.keep ? i_word.bin_idx[IW-1:0] : IW'(MAX_BINS - 1);
                    if (i_word.sample_size == '0) begin
                        n_stat_word             = '0;
                        n_stat_word.status      = htc_pkg::ST_ZERO;
                        n_stat_word.last_result = 1'b1;
                        n_state                 = htc_pkg::S_STAT;
                    end else begin
                        n_addr  = '0;
                        n_more  = 1'b1;
                        n_sum   = '0;
                        n_state = htc_pkg::S_LSCAN;
                    end
                end
            end

            htc_pkg::S_LSCAN: begin
                s_fin   = r_rd_valid && (s_hit || r_rd_idx == r_last_idx);
                s_issue = r_more && !s_fin;
                if (r_rd_valid) begin
                    if (s_hit) begin
                        n_i     = r_rd_idx;
                        n_lsum  = r_sum;
                        n_sum   = '0;
                        n_addr  = r_last_idx;
                        n_more  = 1'b1;
                        n_state = htc_pkg::S_RSCAN;
                    end else if (r_rd_idx == r_last_idx) begin
                        n_stat_word = s_impl_word;
                        n_state     = htc_pkg::S_STAT;
                    end else begin
                        n_sum = s_sum[FW-1:0];
                    end
                end
            end

            htc_pkg::S_RSCAN: begin
                s_fin   = r_rd_valid && (s_hit || r_rd_idx == '0);
                s_issue = r_more && !s_fin;
                if (r_rd_valid) begin
                    if (s_hit) begin
                        n_j    = r_rd_idx;
                        n_rsum = r_sum;
                        if (r_i > r_rd_idx) begin
                            n_stat_word = s_impl_word;
                            n_state     = htc_pkg::S_STAT;
                        end else if (r_i == r_rd_idx) begin
                            n_stat_word             = '0;
                            n_stat_word.bin_index   = htc_pkg::t_idx'(r_i);
                            n_stat_word.left_cut    = htc_pkg::t_idx'(r_i);
                            n_stat_word.right_cut   = htc_pkg::t_idx'(r_i);
                            n_stat_word.peak_index  = htc_pkg::t_idx'(r_i);
                            n_stat_word.status      = htc_pkg::ST_SINGLE;
                            n_stat_word.last_result = 1'b1;
                            n_state                 = htc_pkg::S_STAT;
                        end else if (s_small) begin
                            n_stat_word             = '0;
                            n_stat_word.left_cut    = htc_pkg::t_idx'(r_i);
                            n_stat_word.right_cut   = htc_pkg::t_idx'(r_rd_idx);
                            n_stat_word.peak_index  = htc_pkg::t_idx'(r_last_idx);
                            n_stat_word.status      = htc_pkg::ST_SMALL;
                            n_stat_word.last_result = 1'b1;
                            n_state                 = htc_pkg::S_STAT;
                        end else begin
                            n_addr  = r_i;
                            n_more  = 1'b1;
                            n_best  = '0;
                            n_peak  = r_i;
                            n_state = htc_pkg::S_PEAK;
                        end
                    end else if (r_rd_idx == '0) begin
                        n_stat_word = s_impl_word;
                        n_state     = htc_pkg::S_STAT;
                    end else begin
                        n_sum = s_sum[FW-1:0];
                    end
                end
            end

            htc_pkg::S_PEAK: begin
                s_fin   = r_rd_valid && r_rd_idx == r_j;
                s_issue = r_more && !s_fin;
                // strict compare keeps the first bin on ties
                if (r_rd_valid && r_rd_data > r_best) begin
                    n_best = r_rd_data;
                    n_peak = r_rd_idx;
                end
                if (s_fin) begin
                    n_addr  = r_i;
                    n_more  = 1'b1;
                    n_state = htc_pkg::S_EMIT;
                end
            end

            htc_pkg::S_EMIT: begin
                s_out_load = r_rd_valid && s_can_load;
                s_consume  = s_out_load;
                s_fin      = s_out_load && r_rd_idx == r_j;
                s_issue    = r_more && (!r_rd_valid || s_out_load) && !s_fin;
                if (s_out_load) begin
                    n_out_valid = 1'b1;
                    n_out       = s_emit_word;
                end
                if (s_fin) begin
                    n_state = htc_pkg::S_LOAD;
                end
            end

            htc_pkg::S_STAT: begin
                if (s_can_load) begin
                    n_out_valid = 1'b1;
                    n_out       = r_stat_word;
                    n_state     = htc_pkg::S_LOAD;
                end
            end

            default: begin
                n_state = htc_pkg::S_LOAD;
            end
        endcase

        // address walk, downwards for the right scan
        if (s_issue) begin
            if (r_state == htc_pkg::S_RSCAN) begin
                if (r_addr == '0) begin
                    n_more = 1'b0;
                end else begin
                    n_addr = r_addr - 1'b1;
                end
            end else begin
                if (r_addr == s_stop) begin
                    n_more = 1'b0;
                end else begin
                    n_addr = r_addr + 1'b1;
                end
            end
        end

        n_rd_valid = s_issue || (r_rd_valid && !s_consume);
    end

    // bin store: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (o_pop && i_word.keep) begin
            r_mem[i_word.bin_idx[IW-1:0]] <= i_word.bin_value[SB-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_issue) begin
            r_rd_data <= r_mem[r_addr];
            r_rd_idx  <= r_addr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= htc_pkg::S_LOAD;
            r_more      <= 1'b0;
            r_rd_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_more      <= n_more;
            r_rd_valid  <= n_rd_valid;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_addr      <= n_addr;
        r_sum       <= n_sum;
        r_lsum      <= n_lsum;
        r_rsum      <= n_rsum;
        r_i         <= n_i;
        r_j         <= n_j;
        r_last_idx  <= n_last_idx;
        r_ss        <= n_ss;
        r_best      <= n_best;
        r_peak      <= n_peak;
        r_stat_word <= n_stat_word;
        r_out       <= n_out;
    end

    // no read may be in flight outside the walking states
    a_no_read_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == htc_pkg::S_LOAD || r_state == htc_pkg::S_STAT) |-> !r_rd_valid)
        else $error("read in flight while idle or reporting status");

    // peak search and emission only run on a proper kept range
    a_cuts_ordered: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == htc_pkg::S_PEAK || r_state == htc_pkg::S_EMIT) |-> r_i < r_j)
        else $error("cuts not ordered during peak search or emission");

    // emitted bins lie inside the cuts
    a_emit_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.status == htc_pkg::ST_OK) |->
            (r_out.left_cut <= r_out.bin_index && r_out.bin_index <= r_out.right_cut))
        else $error("emitted bin outside the kept range");

    // folded left tail never exceeds the bound
    a_left_tail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == htc_pkg::S_RSCAN) |-> r_lsum <= i_tail_bound)
        else $error("left tail mass above the bound");

endmodule

// ----- verif/tb_top.sv -----
`timescale 1ns / 100ps
// ============================================================================
// tb_top
// self-checking bench for the histogram tail compressor: histograms are fed
// word by word, a local model of the trimming works out the result words and
// the monitor checks each one; both sides idle and stall at random
// ============================================================================
module tb_top;

    localparam int FW             = htc_pkg::FIELD_W;
    localparam int IW             = htc_pkg::IDX_W;
    localparam int MW             = htc_pkg::MERGED_W;
    localparam int CLK_PERIOD     = 10;
    localparam int RESET_CYCLES   = 6;
    localparam int MAX_BINS       = htc_pkg::MAX_BINS_DEF;
    localparam int VALUE_BITS     = htc_pkg::VALUE_BITS_DEF;
    localparam logic [FW-1:0] VALUE_MASK =
        (VALUE_BITS >= FW) ? {FW{1'b1}} : FW'((1 << VALUE_BITS) - 1);
    localparam logic [31:0] MERGED_CEIL = (32'd1 << MW) - 1;

    // addresses outside the register map, written once to show they do nothing
    localparam htc_pkg::t_cfg_idx REG_UNMAPPED_LO = 2'd2;
    localparam htc_pkg::t_cfg_idx REG_UNMAPPED_HI = 2'd3;

    // receiver hold-off long enough for the input queue to fill and stall
    localparam int LONG_HOLD      = 400;
    // quiet cycles waited before a new setting is written
    localparam int SETTLE_CYCLES  = 20;
    // tail of the run once nothing is awaited
    localparam int DRAIN_CYCLES   = 50;
    // longest legal stretch without a handshake is the long hold plus a full
    // 64-bin walk, so this leaves ample margin
    localparam int WATCHDOG_LIMIT = 5000;

    // value profiles for random histograms
    typedef enum int {
        SHAPE_SPREAD,
        SHAPE_BELL,
        SHAPE_FAINT,
        SHAPE_SPIKE
    } t_shape;

    // clock and reset
    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    always #(CLK_PERIOD / 2) clk = ~clk;

    // block ports
    logic                 in_valid  = 1'b0;
    logic                 in_stall;
    htc_pkg::t_in_word    in_word   = '0;
    logic                 out_valid;
    logic                 out_stall = 1'b0;
    htc_pkg::t_out_word   out_word;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    htc_pkg::t_cfg_idx    cfg_index = htc_pkg::REG_TAIL_BOUND;
    logic [FW-1:0]        cfg_data  = '0;

    histogram_tail_compressor #(
        .MAX_BINS   (MAX_BINS),
        .VALUE_BITS (VALUE_BITS)
    ) u_top (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in        (in_word),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out       (out_word),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    // ------------------------------------------------------------------------
    // shadow of the block: register copies, loaded bins, awaited results
    // ------------------------------------------------------------------------
    logic [FW-1:0] bound_copy = htc_pkg::TAIL_BOUND_RST;
    logic [FW-1:0] min_copy   = htc_pkg::MIN_SAMPLE_RST;
    logic [FW-1:0] bin_mem [MAX_BINS];
    int            held_count;

    htc_pkg::t_in_word  pending_bins  [$];   // words waiting for the driver
    htc_pkg::t_out_word awaited_words [$];   // result words still to come

    // run statistics
    int words_in;
    int histograms_in;
    int results_seen;
    int mismatches;
    int settings_used;
    int status_tally [5];

    // idle length for either side: mostly none, some short, a few long
    function automatic int pick_idle();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 55)
            return 0;
        else if (roll < 90)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 40);
    endfunction

    function automatic void push_result(input int idx, input logic [31:0] val, input int lc,
                                        input int rc, input int pk,
                                        input htc_pkg::t_status st, input logic last);
        htc_pkg::t_out_word w;
        w.bin_index    = idx[IW-1:0];
        w.merged_value = (val > MERGED_CEIL) ? MERGED_CEIL[MW-1:0] : val[MW-1:0];
        w.left_cut     = lc[IW-1:0];
        w.right_cut    = rc[IW-1:0];
        w.peak_index   = pk[IW-1:0];
        w.status       = st;
        w.last_result  = last;
        awaited_words.push_back(w);
        status_tally[int'(st)]++;
    endfunction

    // trim one loaded histogram and queue the words it should give
    task automatic trim_histogram(input logic [FW-1:0] sample);
        int n, lc, rc, k, pk;
        logic [31:0] run, left_mass, right_mass;
        n = held_count;
        if (sample == 0) begin
            push_result(0, 0, 0, 0, 0, htc_pkg::ST_ZERO, 1'b1);
        end else begin
            // left cut: first bin where the running sum passes the bound
            run = 0;
            for (lc = 0; lc < n; lc++) begin
                run += bin_mem[lc];
                if (run > bound_copy)
                    break;
            end
            // right cut: same walk from the top
            run = 0;
            for (rc = n - 1; rc >= 0; rc--) begin
                run += bin_mem[rc];
                if (run > bound_copy)
                    break;
            end
            if (lc >= n || rc < 0 || lc > rc) begin
                push_result(0, 0, 0, 0, 0, htc_pkg::ST_IMPL, 1'b1);
            end else if (lc == rc) begin
                push_result(lc, 0, lc, rc, lc, htc_pkg::ST_SINGLE, 1'b1);
            end else if (min_copy != 0 && sample < min_copy) begin
                // peak field reports the last loaded index here
                push_result(0, 0, lc, rc, n - 1, htc_pkg::ST_SMALL, 1'b1);
            end else begin
                left_mass  = 0;
                right_mass = 0;
                for (k = 0; k < lc; k++)
                    left_mass += bin_mem[k];
                for (k = rc + 1; k < n; k++)
                    right_mass += bin_mem[k];
                // first maximum wins on ties
                pk = lc;
                for (k = lc + 1; k <= rc; k++)
                    if (bin_mem[k] > bin_mem[pk])
                        pk = k;
                for (k = lc; k <= rc; k++)
                    push_result(k, 32'(bin_mem[k]) + ((k == lc) ? left_mass : 32'd0)
                                + ((k == rc) ? right_mass : 32'd0),
                                lc, rc, pk, htc_pkg::ST_OK, k == rc);
            end
        end
    endtask

    // one accepted bin word: store it, and on the last bin trim the histogram
    task automatic absorb_bin(input htc_pkg::t_in_word w);
        if (held_count < MAX_BINS) begin
            bin_mem[held_count] = w.bin_value & VALUE_MASK;
            held_count++;
        end
        if (w.last_bin) begin
            trim_histogram(w.sample_size);
            held_count = 0;
            histograms_in++;
        end
    endtask

    // ------------------------------------------------------------------------
    // driver: offers pending bin words, holds a stalled word steady
    // ------------------------------------------------------------------------
    int in_gap;
    int calm_in;

    always @(posedge clk) begin
        if (!rst_n) begin
            in_valid   <= 1'b0;
            in_word    <= '0;
            in_gap     <= 0;
            calm_in    <= 0;
            held_count = 0;
        end else begin
            if (in_valid && !in_stall) begin
                absorb_bin(in_word);
                words_in++;
            end
            // move on only once the current word is gone
            if (!in_valid || !in_stall) begin
                if (in_gap > 0) begin
                    in_gap   <= in_gap - 1;
                    in_valid <= 1'b0;
                end else if (pending_bins.size() != 0) begin
                    in_word  <= pending_bins.pop_front();
                    in_valid <= 1'b1;
                    if (calm_in > 0) begin
                        // back-to-back stretch
                        calm_in <= calm_in - 1;
                        in_gap  <= 0;
                    end else begin
                        in_gap <= pick_idle();
                        if ($urandom_range(0, 29) == 0)
                            calm_in <= $urandom_range(20, 60);
                    end
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // receiver stall: random stalls, calm stretches, and the long hold-off
    // that the stimulus asks for by toggling hold_req
    // ------------------------------------------------------------------------
    logic hold_req  = 1'b0;
    logic hold_seen;
    int   hold_left;
    int   stall_run;
    int   calm_out;
    int   stall_len;

    always @(posedge clk) begin
        if (!rst_n) begin
            out_stall <= 1'b0;
            hold_seen <= 1'b0;
            hold_left <= 0;
            stall_run <= 0;
            calm_out  <= 0;
        end else if (hold_left > 0) begin
            out_stall <= 1'b1;
            hold_left <= hold_left - 1;
        end else if (hold_seen != hold_req) begin
            hold_seen <= hold_req;
            hold_left <= LONG_HOLD - 1;
            out_stall <= 1'b1;
        end else if (stall_run > 0) begin
            out_stall <= 1'b1;
            stall_run <= stall_run - 1;
        end else if (calm_out > 0) begin
            out_stall <= 1'b0;
            calm_out  <= calm_out - 1;
        end else begin
            stall_len = pick_idle();
            out_stall <= (stall_len != 0);
            stall_run <= (stall_len > 1) ? stall_len - 1 : 0;
            if (stall_len == 0 && $urandom_range(0, 39) == 0)
                calm_out <= $urandom_range(30, 80);
        end
    end

    // ------------------------------------------------------------------------
    // monitor: every accepted result word against the oldest awaited one
    // ------------------------------------------------------------------------
    task automatic compare_result(input htc_pkg::t_out_word want,
                                  input htc_pkg::t_out_word got);
        logic bad;
        bad = (got.bin_index    !== want.bin_index)
           || (got.merged_value !== want.merged_value)
           || (got.left_cut     !== want.left_cut)
           || (got.right_cut    !== want.right_cut)
           || (got.peak_index   !== want.peak_index)
           || (got.status       !== want.status)
           || (got.last_result  !== want.last_result);
        if (bad) begin
            mismatches++;
            if (mismatches <= 10) begin
                $display("result %0d wrong: want idx %0d val %0d cuts %0d..%0d %s",
                         results_seen, want.bin_index, want.merged_value, want.left_cut,
                         want.right_cut,
                         $sformatf("peak %0d st %0d last %0b", want.peak_index,
                                   want.status, want.last_result));
                $display("    got  idx %0d val %0d cuts %0d..%0d peak %0d st %0d last %0b",
                         got.bin_index, got.merged_value, got.left_cut, got.right_cut,
                         got.peak_index, got.status, got.last_result);
            end
        end
    endtask

    always @(posedge clk) begin
        if (rst_n && out_valid && !out_stall) begin
            results_seen++;
            if (awaited_words.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("result %0d arrived with nothing awaited: idx %0d val %0d st %0d",
                             results_seen, out_word.bin_index, out_word.merged_value,
                             out_word.status);
            end else begin
                compare_result(awaited_words.pop_front(), out_word);
            end
        end
    end

    // ------------------------------------------------------------------------
    // watchdog: ends the run after too long without any handshake
    // ------------------------------------------------------------------------
    int quiet;

    always @(posedge clk) begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)
            || (cfg_valid && cfg_ready)) begin
            quiet <= 0;
        end else if (quiet >= WATCHDOG_LIMIT) begin
            $display("no handshake for %0d cycles, %0d results still awaited",
                     quiet, awaited_words.size());
            $display("Mismatches found");
            $finish;
        end else begin
            quiet <= quiet + 1;
        end
    end

    // ------------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------------
    task automatic push_bin(input logic [FW-1:0] value, input logic [FW-1:0] ssz,
                            input logic last);
        htc_pkg::t_in_word w;
        w.bin_value   = value;
        w.sample_size = ssz;
        w.last_bin    = last;
        pending_bins.push_back(w);
    endtask

    // bins before the last carry junk sample sizes, which must be ignored
    task automatic push_last(input logic [FW-1:0] value, input logic [FW-1:0] ssz);
        push_bin(value, ssz, 1'b1);
    endtask

    task automatic push_body(input logic [FW-1:0] value);
        push_bin(value, FW'($urandom), 1'b0);
    endtask

    // one histogram of the given size and profile
    task automatic add_histogram(input int nbins, input t_shape shape,
                                 input logic [FW-1:0] ssz);
        int k, tail_len, spot;
        logic [FW-1:0] v;
        tail_len = $urandom_range(0, nbins / 3);
        spot     = $urandom_range(0, nbins - 1);
        for (k = 0; k < nbins; k++) begin
            case (shape)
                SHAPE_SPREAD: begin
                    v = FW'($urandom);
                end
                SHAPE_BELL: begin
                    // light tails so that the cuts land inside
                    if (k < tail_len || k >= nbins - tail_len)
                        v = FW'($urandom_range(0, bound_copy / (tail_len + 1)));
                    else
                        v = FW'($urandom_range(0, 65535));
                end
                SHAPE_FAINT: begin
                    // sums hover around the bound: crossing and missing cuts
                    v = FW'($urandom_range(0, bound_copy / 2 + 1));
                end
                default: begin
                    if (k == spot)
                        v = FW'($urandom_range(32768, 65535));
                    else if ($urandom_range(0, 3) == 0)
                        v = FW'($urandom_range(0, 3));
                    else
                        v = '0;
                end
            endcase
            if (k == nbins - 1)
                push_last(v, ssz);
            else
                push_body(v);
        end
    endtask

    // sample size leaning on the zero and minimum-size corners
    function automatic logic [FW-1:0] pick_sample();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 10)
            return '0;
        else if (roll < 35 && min_copy > 1)
            return FW'($urandom_range(1, min_copy - 1));
        else if (roll < 42)
            return min_copy;
        else if (roll < 50)
            return '1;
        else
            return FW'($urandom_range(1, 65535));
    endfunction

    // random histograms until roughly the given number of bin words is queued
    task automatic random_batch(input int target);
        int queued, nbins, roll;
        queued = 0;
        while (queued < target) begin
            roll = $urandom_range(0, 99);
            if (roll < 85)
                nbins = $urandom_range(1, 10);
            else if (roll < 96)
                nbins = $urandom_range(11, 40);
            else
                nbins = $urandom_range(60, 68);
            add_histogram(nbins, t_shape'($urandom_range(0, 3)), pick_sample());
            queued += nbins;
        end
    endtask

    // sender holds back until the block has handed over everything; looked
    // at between edges so that the driver's updates have all landed
    task automatic wait_drained();
        @(negedge clk);
        while (pending_bins.size() != 0 || in_valid || awaited_words.size() != 0)
            @(negedge clk);
    endtask

    task automatic write_reg(input htc_pkg::t_cfg_idx idx, input logic [FW-1:0] data);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        case (idx)
            htc_pkg::REG_TAIL_BOUND: bound_copy = data;
            htc_pkg::REG_MIN_SAMPLE: min_copy   = data;
            default: ;
        endcase
    endtask

    // new setting, only once the block has gone quiet
    task automatic new_setting(input logic [FW-1:0] bound, input logic [FW-1:0] min_size);
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
        write_reg(htc_pkg::REG_TAIL_BOUND, bound);
        write_reg(htc_pkg::REG_MIN_SAMPLE, min_size);
        settings_used++;
    endtask

    // ------------------------------------------------------------------------
    // test sequence
    // ------------------------------------------------------------------------
    initial begin
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        settings_used = 1;

        // reset setting: bound 328, no minimum
        push_last(16'hFFFF, 16'd0);                 // zero sample skipped
        push_last(16'hFFFF, 16'hFFFF);              // one big bin, cuts meet
        push_last(16'd0, 16'd1);                    // bound never passed
        push_body(16'd200);                         // cuts cross
        push_last(16'd200, 16'd3);
        push_body(16'd100);                         // left tail folded into bin 1
        push_body(16'd300);
        push_body(16'd5);
        push_body(16'hFFFF);
        push_body(16'd7);
        push_last(16'd400, 16'h5A5A);
        push_body(16'd329);                         // equal bins, first peak wins
        push_last(16'd329, 16'h0001);

        // zero bound, largest minimum
        new_setting(16'd0, 16'hFFFF);
        push_body(16'd0);
        push_body(16'd1);
        push_body(16'd0);
        push_last(16'd2, 16'hFFFF);
        push_body(16'd5);                           // sample just below minimum
        push_last(16'd5, 16'hFFFE);

        // largest bound, minimum off
        new_setting(16'hFFFF, 16'd0);
        push_body(16'hFFFF);                        // cuts cross at the top bound
        push_last(16'd1, 16'h8000);
        push_body(16'd40000);
        push_body(16'd40000);
        push_last(16'd40000, 16'h7FFF);

        // random: modest bound, unmapped addresses poked on the way
        new_setting(16'($urandom_range(1, 2000)), 16'd0);
        write_reg(REG_UNMAPPED_LO, 16'($urandom));
        write_reg(REG_UNMAPPED_HI, 16'($urandom));
        random_batch(15);

        // random: any bound and minimum, an overfull histogram, and a long
        // receiver hold-off while the sender keeps offering words
        new_setting(16'($urandom), 16'($urandom));
        add_histogram(66, SHAPE_BELL, pick_sample());
        random_batch(15);
        @(posedge clk);
        hold_req <= ~hold_req;

        // random: reset bound with a small minimum, sender pauses halfway
        new_setting(16'd328, 16'($urandom_range(1, 2000)));
        random_batch(10);
        wait_drained();
        random_batch(10);

        // random: any bound, full-size histogram
        new_setting(16'($urandom), 16'd0);
        add_histogram(64, SHAPE_SPREAD, pick_sample());
        random_batch(15);

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (awaited_words.size() != 0) begin
            $display("%0d result words never arrived", awaited_words.size());
            mismatches += awaited_words.size();
        end

        $display("run covered %0d bin words in %0d histograms under %0d register settings",
                 words_in, histograms_in, settings_used);
        $display("%0d result words: ok %0d, zero sample %0d, single slot %0d, %s",
                 results_seen, status_tally[htc_pkg::ST_OK], status_tally[htc_pkg::ST_ZERO],
                 status_tally[htc_pkg::ST_SINGLE],
                 $sformatf("small %0d, implausible %0d", status_tally[htc_pkg::ST_SMALL],
                           status_tally[htc_pkg::ST_IMPL]));
        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

// ----- files.f -----
hdl/htc_pkg.sv
hdl/htc_front.sv
hdl/htc_fifo.sv
hdl/htc_back.sv
hdl/histogram_tail_compressor.sv
verif/tb_top.sv
